// ----- hdl/i2cm_pkg.sv -----
// Shared types and constants for the I2C master bit engine.
package i2cm_pkg;

   // Command codes carried on the request tuser field
   typedef enum logic [2:0] {
      CMD_TICK  = 3'd0,
      CMD_START = 3'd1,
      CMD_STOP  = 3'd2,
      CMD_SEND  = 3'd3,
      CMD_WAIT  = 3'd4,
      CMD_READ  = 3'd5,
      CMD_RSV6  = 3'd6,
      CMD_RSV7  = 3'd7
   } cmd_type;

   // Configuration register indexes
   localparam logic [7:0] CSR_TICKS_PER_US = 8'd0;
   localparam logic [7:0] CSR_ACK_TIMEOUT  = 8'd1;

   // Configuration reset values
   localparam logic [7:0] TICKS_PER_US_RESET = 8'd1;
   localparam logic [7:0] ACK_TIMEOUT_RESET  = 8'd250;

   // One result item of the sequencer
   typedef struct packed {
      logic       command_rejected;
      logic       ack_failed;
      logic [7:0] rx_byte;
      logic       done_res;
      logic       busy_res;
      logic       sda_out;
      logic       scl_out;
   } result_type;

endpackage

// ----- hdl/i2cm_core.sv -----
// Line sequencer: command decode, delay timing, bit shifting and line levels.
module i2cm_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [2:0]           command,
   input  logic [7:0]           tx_byte,
   input  logic                 master_ack,
   input  logic                 sda_in,
   input  logic                 csr_write,
   input  logic [7:0]           csr_index,
   input  logic [7:0]           csr_data,
   output i2cm_pkg::result_type result
);

   typedef enum logic [3:0] {
      PH_IDLE    = 4'd0,
      PH_ST_A    = 4'd1,
      PH_ST_B    = 4'd2,
      PH_SP_A    = 4'd3,
      PH_SP_B    = 4'd4,
      PH_TX_LOW  = 4'd5,
      PH_TX_HIGH = 4'd6,
      PH_TX_TAIL = 4'd7,
      PH_WA_A    = 4'd8,
      PH_WA_B    = 4'd9,
      PH_WA_POLL = 4'd10,
      PH_RX_LOW  = 4'd11,
      PH_RX_HIGH = 4'd12,
      PH_AK_LOW  = 4'd13,
      PH_AK_HIGH = 4'd14
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [9:0] delay_ff, delay_in;
   logic [3:0] bits_ff, bits_in;
   logic [7:0] shift_ff, shift_in;
   logic [7:0] timeout_ff, timeout_in;
   logic       scl_ff, scl_in;
   logic       sda_ff, sda_lvl_in;
   logic       ack_choice_ff, ack_choice_in;
   logic       fail_ff, fail_in;
   logic [7:0] last_rx_ff, last_rx_in;
   logic [7:0] tpu_ff;
   logic [7:0] limit_ff;

   logic [9:0] wait_1, wait_2, wait_4;
   logic [9:0] delay_dec;
   logic [3:0] bits_inc;
   logic       finish;
   logic       rejected;

   // Delay lengths in ticks for one, two and four units
   assign wait_1    = {2'b00, tpu_ff};
   assign wait_2    = {1'b0, tpu_ff, 1'b0};
   assign wait_4    = {tpu_ff, 2'b00};
   assign delay_dec = (delay_ff != 10'd0) ? delay_ff - 10'd1 : delay_ff;
   assign bits_inc  = bits_ff + 4'd1;

   // Next state for one tick
   always_comb begin
      phase_in      = phase_ff;
      delay_in      = delay_ff;
      bits_in       = bits_ff;
      shift_in      = shift_ff;
      timeout_in    = timeout_ff;
      scl_in        = scl_ff;
      sda_lvl_in    = sda_ff;
      ack_choice_in = ack_choice_ff;
      fail_in       = fail_ff;
      last_rx_in    = last_rx_ff;
      finish        = 1'b0;
      rejected      = 1'b0;
      if (phase_ff != PH_IDLE) begin
         rejected = (command >= i2cm_pkg::CMD_START) && (command <= i2cm_pkg::CMD_READ);
         delay_in = delay_dec;
         if (delay_dec == 10'd0) begin
            unique case (phase_ff)
               PH_ST_A: begin
                  sda_lvl_in = 1'b0;
                  phase_in   = PH_ST_B;
                  delay_in   = wait_4;
               end
               PH_ST_B: begin
                  scl_in = 1'b0;
                  finish = 1'b1;
               end
               PH_SP_A: begin
                  scl_in     = 1'b1;
                  sda_lvl_in = 1'b1;
                  phase_in   = PH_SP_B;
                  delay_in   = wait_4;
               end
               PH_TX_LOW: begin
                  scl_in   = 1'b1;
                  phase_in = PH_TX_HIGH;
                  delay_in = wait_2;
               end
               PH_TX_HIGH: begin
                  scl_in   = 1'b0;
                  phase_in = PH_TX_TAIL;
                  delay_in = wait_2;
               end
               PH_TX_TAIL: begin
                  bits_in = bits_inc;
                  if (bits_inc >= 4'd8) begin
                     finish = 1'b1;
                  end else begin
                     sda_lvl_in = shift_ff[7];
                     shift_in   = {shift_ff[6:0], 1'b0};
                     phase_in   = PH_TX_LOW;
                     delay_in   = wait_2;
                  end
               end
               PH_WA_A: begin
                  scl_in   = 1'b1;
                  phase_in = PH_WA_B;
                  delay_in = wait_1;
               end
               PH_WA_B: begin
                  phase_in = PH_WA_POLL;
                  delay_in = 10'd0;
               end
               PH_WA_POLL: begin
                  if (!sda_in) begin
                     scl_in  = 1'b0;
                     fail_in = 1'b0;
                     finish  = 1'b1;
                  end else if (timeout_ff == limit_ff) begin
                     // give up and release the bus with a stop
                     fail_in    = 1'b1;
                     sda_lvl_in = 1'b0;
                     phase_in   = PH_SP_A;
                     delay_in   = wait_4;
                  end else begin
                     timeout_in = timeout_ff + 8'd1;
                  end
               end
               PH_RX_LOW: begin
                  scl_in   = 1'b1;
                  phase_in = PH_RX_HIGH;
                  delay_in = wait_1;
               end
               PH_RX_HIGH: begin
                  shift_in = {shift_ff[6:0], sda_in};
                  bits_in  = bits_inc;
                  scl_in   = 1'b0;
                  if (bits_inc >= 4'd8) begin
                     last_rx_in = {shift_ff[6:0], sda_in};
                     sda_lvl_in = !ack_choice_ff;
                     phase_in   = PH_AK_LOW;
                  end else begin
                     phase_in = PH_RX_LOW;
                  end
                  delay_in = wait_2;
               end
               PH_AK_LOW: begin
                  scl_in   = 1'b1;
                  phase_in = PH_AK_HIGH;
                  delay_in = wait_2;
               end
               PH_AK_HIGH: begin
                  scl_in = 1'b0;
                  finish = 1'b1;
               end
               default: begin
                  finish = 1'b1;
               end
            endcase
            if (finish) begin
               phase_in = PH_IDLE;
               delay_in = 10'd0;
            end
         end
      end else begin
         // idle: decode a new command
         unique case (command)
            i2cm_pkg::CMD_START: begin
               sda_lvl_in = 1'b1;
               scl_in     = 1'b1;
               phase_in   = PH_ST_A;
               delay_in   = wait_4;
            end
            i2cm_pkg::CMD_STOP: begin
               sda_lvl_in = 1'b0;
               phase_in   = PH_SP_A;
               delay_in   = wait_4;
            end
            i2cm_pkg::CMD_SEND: begin
               scl_in     = 1'b0;
               bits_in    = 4'd0;
               sda_lvl_in = tx_byte[7];
               shift_in   = {tx_byte[6:0], 1'b0};
               phase_in   = PH_TX_LOW;
               delay_in   = wait_2;
            end
            i2cm_pkg::CMD_WAIT: begin
               sda_lvl_in = 1'b1;
               timeout_in = 8'd0;
               phase_in   = PH_WA_A;
               delay_in   = wait_1;
            end
            i2cm_pkg::CMD_READ: begin
               sda_lvl_in    = 1'b1;
               scl_in        = 1'b0;
               shift_in      = 8'd0;
               bits_in       = 4'd0;
               ack_choice_in = master_ack;
               phase_in      = PH_RX_LOW;
               delay_in      = wait_2;
            end
            default: begin
            end
         endcase
      end
   end

   // Result of this tick, taken by the output buffer on step
   always_comb begin
      result.scl_out          = scl_in;
      result.sda_out          = sda_lvl_in;
      result.busy_res         = (phase_in != PH_IDLE);
      result.done_res         = finish;
      result.rx_byte          = last_rx_in;
      result.ack_failed       = fail_in;
      result.command_rejected = rejected;
   end

   // Hold sequencer state and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         delay_ff      <= 10'd0;
         bits_ff       <= 4'd0;
         shift_ff      <= 8'd0;
         timeout_ff    <= 8'd0;
         scl_ff        <= 1'b1;
         sda_ff        <= 1'b1;
         ack_choice_ff <= 1'b0;
         fail_ff       <= 1'b0;
         last_rx_ff    <= 8'd0;
         tpu_ff        <= i2cm_pkg::TICKS_PER_US_RESET;
         limit_ff      <= i2cm_pkg::ACK_TIMEOUT_RESET;
      end else begin
         if (step) begin
            phase_ff      <= phase_in;
            delay_ff      <= delay_in;
            bits_ff       <= bits_in;
            shift_ff      <= shift_in;
            timeout_ff    <= timeout_in;
            scl_ff        <= scl_in;
            sda_ff        <= sda_lvl_in;
            ack_choice_ff <= ack_choice_in;
            fail_ff       <= fail_in;
            last_rx_ff    <= last_rx_in;
         end
         if (csr_write) begin
            if (csr_index == i2cm_pkg::CSR_TICKS_PER_US) begin
               tpu_ff <= csr_data;
            end else if (csr_index == i2cm_pkg::CSR_ACK_TIMEOUT) begin
               limit_ff <= csr_data;
            end
         end
      end
   end

endmodule

// ----- hdl/i2cm_out_buf.sv -----
// Two-entry skid buffer between the sequencer and the response channel.
module i2cm_out_buf (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  i2cm_pkg::result_type in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output i2cm_pkg::result_type out_data
);

   logic                 main_valid_ff;
   logic                 skid_valid_ff;
   i2cm_pkg::result_type main_ff;
   i2cm_pkg::result_type skid_ff;
   logic                 main_load;

   assign in_ready  = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;
   assign main_load = !main_valid_ff || out_ready;

   // Track occupancy of both entries
   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (main_load) begin
         main_valid_ff <= skid_valid_ff || in_valid;
         skid_valid_ff <= 1'b0;
      end else if (in_valid && in_ready) begin
         skid_valid_ff <= 1'b1;
      end
   end

   // Move payload: skid entry drains first
   always_ff @(posedge clock) begin
      if (main_load) begin
         main_ff <= skid_valid_ff ? skid_ff : in_data;
      end else if (in_valid && in_ready) begin
         skid_ff <= in_data;
      end
   end

endmodule

// ----- hdl/i2c_master_bit_engine.sv -----
// I2C master bit engine top level: request/response streams and register port.
// The response for an accepted request is registered in the output buffer.
// Throughput: one request per cycle while the output buffer has room; the sequencer state updates in one pass.
// A two-entry output buffer takes one more request while a response is stalled.
// Reset is synchronous, active high: sequencer idle, both lines released high,
// ticks_per_us = 1, ack_timeout_limit = 250, buffer empty.
module i2c_master_bit_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // tx_byte[7:0], master_ack, sda_in, zero fill
   input  logic [2:0]  req_tuser,   // command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // scl_out, sda_out, busy_res, done_res, rx_byte[7:0],
                                    // ack_failed, command_rejected, zero fill
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [7:0]  csr_data
);

   i2cm_pkg::result_type core_result;
   i2cm_pkg::result_type rsp_result;
   logic                 req_accept;

   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // Sequencer steps once per accepted request
   i2cm_core u_core (
      .clock      (clock),
      .reset      (reset),
      .step       (req_accept),
      .command    (req_tuser),
      .tx_byte    (req_tdata[7:0]),
      .master_ack (req_tdata[8]),
      .sda_in     (req_tdata[9]),
      .csr_write  (csr_valid && csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .result     (core_result)
   );

   // Buffer responses toward the master side
   i2cm_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (core_result),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_result)
   );

   // Pack response fields, first field lowest
   assign rsp_tdata = {2'b00,
                       rsp_result.command_rejected,
                       rsp_result.ack_failed,
                       rsp_result.rx_byte,
                       rsp_result.done_res,
                       rsp_result.busy_res,
                       rsp_result.sda_out,
                       rsp_result.scl_out};

endmodule
